>>> rtl/imu_offset_calibration_assert.svh
// Assertion macros for the IMU offset calibration block
`ifndef IMU_OFFSET_CALIBRATION_ASSERT_SVH
`define IMU_OFFSET_CALIBRATION_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IMU_OFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IMU_OFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/imu_ofs_pkg.sv
// Package: types, codes and widths of the IMU offset calibration block
`timescale 1ns / 1ps

package imu_ofs_pkg;

	localparam int SMP_W     = 16;
	localparam int OFS_W     = 18;
	localparam int SUM_W     = 32;
	localparam int CFG_W     = 15;
	localparam int NUM_AXES  = 6;
	localparam int CAL_AXES  = 3;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	localparam logic [CFG_W-1:0] CAL_SAMPLES_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] ONE_G_RST       = CFG_W'(16384);

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_GYRO   = 2'd1;
	localparam logic [1:0] REQ_ACCEL  = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd3;

	localparam logic [1:0] CFG_BYPASS  = 2'd0;
	localparam logic [1:0] CFG_SAMPLES = 2'd1;
	localparam logic [1:0] CFG_ONE_G   = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_GYRO  = 2'd1,
		MODE_ACCEL = 2'd2
	} cal_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/imu_ofs_in_if.sv
// Sample request channel: valid/ready with request code and raw six-axis sample
`timescale 1ns / 1ps

interface imu_ofs_in_if import imu_ofs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              req_type;
	logic                    data_ready;
	logic signed [SMP_W-1:0] accel_x;
	logic signed [SMP_W-1:0] accel_y;
	logic signed [SMP_W-1:0] accel_z;
	logic signed [SMP_W-1:0] gyro_x;
	logic signed [SMP_W-1:0] gyro_y;
	logic signed [SMP_W-1:0] gyro_z;

	modport source (
		output valid, req_type, data_ready, accel_x, accel_y, accel_z,
			gyro_x, gyro_y, gyro_z,
		input  ready
	);
	modport sink (
		input  valid, req_type, data_ready, accel_x, accel_y, accel_z,
			gyro_x, gyro_y, gyro_z,
		output ready
	);
endinterface

>>> rtl/imu_ofs_out_if.sv
// Result channel: valid/ready with corrected six-axis sample and calibration status
`timescale 1ns / 1ps

interface imu_ofs_out_if import imu_ofs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] out_accel_x;
	logic signed [SMP_W-1:0] out_accel_y;
	logic signed [SMP_W-1:0] out_accel_z;
	logic signed [SMP_W-1:0] out_gyro_x;
	logic signed [SMP_W-1:0] out_gyro_y;
	logic signed [SMP_W-1:0] out_gyro_z;
	logic [1:0]              cal_status;

	modport source (
		output valid, out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y,
			out_gyro_z, cal_status,
		input  ready
	);
	modport sink (
		input  valid, out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y,
			out_gyro_z, cal_status,
		output ready
	);
endinterface

>>> rtl/imu_ofs_div.sv
// Serial restoring divider: signed sum over unsigned sample count, truncating
`timescale 1ns / 1ps

module imu_ofs_div import imu_ofs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CFG_W-1:0]        divisor,
	output div_stat_t               stat,
	output logic signed [SUM_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CFG_W-1:0]     rem_q;
	logic [CFG_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [CFG_W:0]   shifted;
	logic [CFG_W+1:0] diff;
	logic             fits;
	logic             last;

	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = !diff[CFG_W+1];
		last    = (cnt_q == DIV_CNT_W'(SUM_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> rtl/imu_offset_calibration.sv
// Top level: IMU sample holding, offset correction and bias calibration sequencer
//
//   channel   kind        members
//   sample    sink        req_type, data_ready, six raw axes
//   result    source      six corrected axes, cal_status
//   cfg_*     write only  raw_bypass, cal_samples, one_g_counts
//
// A plain item is accepted, then loaded into the result register.
// An item that ends a calibration run first waits on the one serial divider,
// which works through the three axes in turn before the result register load.
// Reset clears held samples, offsets, sums and the run state; no clearing pass.
// A stalled result holds the block in its output state; the next request is
// taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "imu_offset_calibration_assert.svh"

module imu_offset_calibration import imu_ofs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	imu_ofs_in_if.sink        sample,
	imu_ofs_out_if.source     result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic             bypass_q;
	logic [CFG_W-1:0] cal_samples_q;
	logic [CFG_W-1:0] one_g_q;

	logic signed [SMP_W-1:0] held_q [NUM_AXES];
	logic signed [OFS_W-1:0] ofs_q  [NUM_AXES];
	logic [SUM_W-1:0]        sum_q  [CAL_AXES];
	logic [CFG_W-1:0]        cnt_q;
	cal_mode_t               mode_q;
	cal_mode_t               fin_mode_q;
	logic [1:0]              axis_q;
	logic [1:0]              status_q;
	logic                    out_valid_q;

	logic signed [SMP_W-1:0] cur [NUM_AXES];
	logic [SUM_W-1:0]        sum_nxt [CAL_AXES];
	logic [CFG_W-1:0]        n_eff;
	logic [CFG_W-1:0]        cnt_inc;
	logic                    fin_now;
	logic                    acc;
	logic                    out_free;
	logic                    div_start;
	logic                    ofs_we;
	logic                    out_load;

	div_stat_t               div_stat;
	logic signed [SUM_W-1:0] div_quo;
	logic signed [SUM_W:0]   avg;
	logic [SUM_W:OFS_W-1]    avg_hi;
	logic signed [OFS_W-1:0] ofs_new;
	logic [2:0]              ofs_idx;

	imu_ofs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[axis_q]),
		.divisor  (n_eff),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// sample in view for this request: new one if flagged, else the held one
	always_comb begin
		cur[0] = sample.data_ready ? sample.accel_x : held_q[0];
		cur[1] = sample.data_ready ? sample.accel_y : held_q[1];
		cur[2] = sample.data_ready ? sample.accel_z : held_q[2];
		cur[3] = sample.data_ready ? sample.gyro_x  : held_q[3];
		cur[4] = sample.data_ready ? sample.gyro_y  : held_q[4];
		cur[5] = sample.data_ready ? sample.gyro_z  : held_q[5];
		for (int k = 0; k < CAL_AXES; k++) begin
			sum_nxt[k] = sum_q[k] + SUM_W'((mode_q == MODE_GYRO) ? cur[k + 3] : cur[k]);
		end
		n_eff   = (cal_samples_q == '0) ? CFG_W'(1) : cal_samples_q;
		cnt_inc = cnt_q + CFG_W'(1);
		fin_now = (mode_q != MODE_IDLE) && ((cnt_inc >= n_eff) || (cnt_inc == '0));
	end

	// offset from truncated average, z-accel less one g, saturated
	always_comb begin
		avg = {div_quo[SUM_W-1], div_quo}
			- ((fin_mode_q == MODE_ACCEL && axis_q == 2'd2) ? (SUM_W+1)'(one_g_q) : '0);
		avg_hi = avg[SUM_W:OFS_W-1];
		if ((&avg_hi) || !(|avg_hi)) begin
			ofs_new = avg[OFS_W-1:0];
		end else begin
			ofs_new = avg[SUM_W] ? {1'b1, {(OFS_W-1){1'b0}}} : {1'b0, {(OFS_W-1){1'b1}}};
		end
		ofs_idx = (fin_mode_q == MODE_GYRO) ? 3'({1'b0, axis_q}) + 3'd3 : 3'({1'b0, axis_q});
	end

	assign out_free = !out_valid_q || result.ready;
	assign acc      = sample.valid && sample.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = fin_now ? ST_DIV_START : ST_OUT;
				end
			end
			ST_DIV_START: begin
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = (axis_q == 2'd2) ? ST_OUT : ST_DIV_START;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == ST_IDLE);
		div_start    = (state_q == ST_DIV_START);
		ofs_we       = (state_q == ST_DIV_WAIT) && div_stat.done;
		out_load     = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bypass_q      <= 1'b0;
			cal_samples_q <= CAL_SAMPLES_RST;
			one_g_q       <= ONE_G_RST;
			mode_q        <= MODE_IDLE;
			fin_mode_q    <= MODE_IDLE;
			cnt_q         <= '0;
			axis_q        <= '0;
			status_q      <= '0;
			out_valid_q   <= 1'b0;
			for (int k = 0; k < NUM_AXES; k++) begin
				held_q[k] <= '0;
				ofs_q[k]  <= '0;
			end
			for (int k = 0; k < CAL_AXES; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BYPASS:  bypass_q      <= cfg_data[0];
					CFG_SAMPLES: cal_samples_q <= cfg_data;
					CFG_ONE_G:   one_g_q       <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				axis_q <= '0;
				if (sample.data_ready) begin
					for (int k = 0; k < NUM_AXES; k++) begin
						held_q[k] <= cur[k];
					end
				end
				if (mode_q == MODE_IDLE
						&& (sample.req_type == REQ_GYRO || sample.req_type == REQ_ACCEL)) begin
					mode_q   <= cal_mode_t'(sample.req_type);
					cnt_q    <= '0;
					status_q <= sample.req_type;
					for (int k = 0; k < CAL_AXES; k++) begin
						sum_q[k] <= '0;
					end
				end else if (mode_q != MODE_IDLE) begin
					for (int k = 0; k < CAL_AXES; k++) begin
						sum_q[k] <= sum_nxt[k];
					end
					if (fin_now) begin
						fin_mode_q <= mode_q;
						mode_q     <= MODE_IDLE;
						cnt_q      <= '0;
						status_q   <= STAT_DONE;
					end else begin
						cnt_q    <= cnt_inc;
						status_q <= mode_q;
					end
				end else begin
					status_q <= MODE_IDLE;
				end
			end
			if (ofs_we) begin
				axis_q <= axis_q + 2'd1;
				for (int k = 0; k < NUM_AXES; k++) begin
					if (ofs_idx == 3'(k)) begin
						ofs_q[k] <= ofs_new;
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.out_accel_x <= bypass_q ? held_q[0] : held_q[0] - ofs_q[0][SMP_W-1:0];
			result.out_accel_y <= bypass_q ? held_q[1] : held_q[1] - ofs_q[1][SMP_W-1:0];
			result.out_accel_z <= bypass_q ? held_q[2] : held_q[2] - ofs_q[2][SMP_W-1:0];
			result.out_gyro_x  <= bypass_q ? held_q[3] : held_q[3] - ofs_q[3][SMP_W-1:0];
			result.out_gyro_y  <= bypass_q ? held_q[4] : held_q[4] - ofs_q[4][SMP_W-1:0];
			result.out_gyro_z  <= bypass_q ? held_q[5] : held_q[5] - ofs_q[5][SMP_W-1:0];
			result.cal_status  <= status_q;
		end
	end

	assign result.valid = out_valid_q;

	`IMU_OFS_ASSERT_NOW(a_div_alive, (state_q == ST_DIV_WAIT && !div_stat.done), div_stat.busy, "divider idle while awaited")
	`IMU_OFS_ASSERT_NOW(a_div_run_ended, (state_q == ST_DIV_START), (mode_q == MODE_IDLE && status_q == STAT_DONE), "division outside finished run")
	`IMU_OFS_ASSERT_NEXT(a_accept_moves, acc, (state_q == ST_OUT || state_q == ST_DIV_START), "request accepted without progress")
	`IMU_OFS_ASSERT_NOW(a_axis_range, (state_q == ST_DIV_WAIT || state_q == ST_DIV_START), (axis_q != 2'd3), "axis index out of range")

endmodule
